@@ src/fws_pkg.sv @@
package fws_pkg;

    // Default parameter values.
    localparam int DEF_MAX_SAMPLES     = 65536;
    localparam int DEF_VALUE_FRAC_BITS = 16;

    // Fixed field widths.
    localparam int TIME_W    = 32;
    localparam int DEV_W     = 16;
    localparam int CH_W      = 8;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SELECT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CEILING    = 3'd5;

    // Controller states.
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_PREP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Current configuration register contents.
    typedef struct packed {
        logic [DEV_W-1:0]          device_select;
        logic [CH_W-1:0]           channel_select;
        logic [TIME_W-1:0]         window_start;
        logic [TIME_W-1:0]         window_end;
        logic signed [VALUE_W-1:0] max_floor;
        logic signed [VALUE_W-1:0] min_ceiling;
    } cfg_regs_t;

    // Writes to the floor and ceiling registers in this cycle.
    typedef struct packed {
        logic                      floor_wr;
        logic                      ceil_wr;
        logic signed [VALUE_W-1:0] wdata;
    } cfg_wr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic capture;
        logic prep;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/fws_ctrl.sv @@
module fws_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last_sample,
    output logic                in_ready,
    input  fws_pkg::dp_status_t status,
    output fws_pkg::ctrl_cmd_t  cmd
);

    fws_pkg::state_t state_reg;
    fws_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fws_pkg::ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a last sample starts the closing division.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fws_pkg::ST_ACCUM:
            begin
                if (in_valid && last_sample)
                begin
                    state_next = fws_pkg::ST_PREP;
                end
            end
            fws_pkg::ST_PREP:
            begin
                state_next = fws_pkg::ST_DIVIDE;
            end
            fws_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = fws_pkg::ST_FINISH;
                end
            end
            fws_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = fws_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = fws_pkg::ST_ACCUM;
            end
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            fws_pkg::ST_ACCUM:
            begin
                in_ready    = 1'b1;
                cmd.acc_en  = in_valid;
                cmd.capture = in_valid && last_sample;
            end
            fws_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            fws_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            fws_pkg::ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/fws_dp.sv @@
module fws_dp
#(
    parameter int MAX_SAMPLES     = fws_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_FRAC_BITS = fws_pkg::DEF_VALUE_FRAC_BITS,
    parameter int CNT_W           = $clog2(MAX_SAMPLES + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fws_pkg::cfg_regs_t                  cfg,
    input  fws_pkg::cfg_wr_t                    cfg_wr,
    input  fws_pkg::ctrl_cmd_t                  cmd,
    output fws_pkg::dp_status_t                 status,
    input  logic [fws_pkg::TIME_W-1:0]          sample_time,
    input  logic [fws_pkg::DEV_W-1:0]           device_id,
    input  logic [fws_pkg::CH_W-1:0]            channel_id,
    input  logic signed [fws_pkg::VALUE_W-1:0]  sample_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fws_pkg::VALUE_W-1:0]  mean_value,
    output logic signed [fws_pkg::VALUE_W-1:0]  max_value,
    output logic signed [fws_pkg::VALUE_W-1:0]  min_value,
    output logic [CNT_W-1:0]                    match_count,
    output logic                                any_matched
);

    localparam int VW     = fws_pkg::VALUE_W;
    localparam int SUM_W  = VW + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic signed [VW-1:0] SENTINEL = VW'(-(64'sd1 <<< VALUE_FRAC_BITS));
    localparam logic signed [VW-1:0] CEIL_RST = VW'(64'sd1 <<< VALUE_FRAC_BITS);

    // Running accumulators of the current set.
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [VW-1:0]    max_reg;
    logic signed [VW-1:0]    min_reg;

    // Closing statistics and divider.
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        divisor_reg;
    logic                    neg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [VW-1:0]    stat_max_reg;
    logic signed [VW-1:0]    stat_min_reg;
    logic [CNT_W-1:0]        stat_cnt_reg;

    // Output register.
    logic                    out_valid_reg;

    logic                    match;
    logic signed [SUM_W-1:0] sum_upd;
    logic [CNT_W-1:0]        cnt_upd;
    logic signed [VW-1:0]    max_upd;
    logic signed [VW-1:0]    min_upd;
    logic [CNT_W:0]          rem_sh;
    logic [CNT_W:0]          rem_diff;
    logic                    rem_ge;
    logic [VW-1:0]           quo_low;

    // Sample filter and updated accumulator values.
    always_comb
    begin
        match = (device_id == cfg.device_select) &&
                (channel_id == cfg.channel_select) &&
                (sample_time > cfg.window_start) &&
                (sample_time < cfg.window_end) &&
                (count_reg < CNT_W'(MAX_SAMPLES));
        sum_upd = sum_reg;
        cnt_upd = count_reg;
        max_upd = max_reg;
        min_upd = min_reg;
        if (match)
        begin
            sum_upd = sum_reg + SUM_W'(sample_value);
            cnt_upd = count_reg + CNT_W'(1);
            if (sample_value > max_reg)
            begin
                max_upd = sample_value;
            end
            if (sample_value < min_reg)
            begin
                min_upd = sample_value;
            end
        end
    end

    // Accumulators: update on each sample, restart after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            max_reg   <= '0;
            min_reg   <= CEIL_RST;
        end
        else if (cmd.capture)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            max_reg   <= cfg.max_floor;
            min_reg   <= cfg.min_ceiling;
        end
        else if (cmd.acc_en)
        begin
            sum_reg   <= sum_upd;
            count_reg <= cnt_upd;
            max_reg   <= max_upd;
            min_reg   <= min_upd;
        end
        else
        begin
            if (cfg_wr.floor_wr && (count_reg == '0))
            begin
                max_reg <= cfg_wr.wdata;
            end
            if (cfg_wr.ceil_wr && (count_reg == '0))
            begin
                min_reg <= cfg_wr.wdata;
            end
        end
    end

    // One restoring division step on the magnitude of the sum.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, divisor_reg};
        rem_ge   = (rem_sh >= {1'b0, divisor_reg});
        quo_low  = quo_reg[VW-1:0];
    end

    // Divider: capture, take the magnitude, then one quotient bit a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            quo_reg      <= sum_upd;
            neg_reg      <= sum_upd[SUM_W-1];
            divisor_reg  <= cnt_upd;
            stat_max_reg <= max_upd;
            stat_min_reg <= min_upd;
            stat_cnt_reg <= cnt_upd;
        end
        else if (cmd.prep)
        begin
            quo_reg  <= neg_reg ? (SUM_W'(0) - quo_reg) : quo_reg;
            rem_reg  <= '0;
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign status.div_done = cmd.div_step && (step_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    // Output request valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, with the sentinel for an empty set.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            match_count <= stat_cnt_reg;
            any_matched <= (stat_cnt_reg != '0);
            if (stat_cnt_reg == '0)
            begin
                mean_value <= SENTINEL;
                max_value  <= SENTINEL;
                min_value  <= SENTINEL;
            end
            else
            begin
                mean_value <= neg_reg ? (VW'(0) - quo_low) : quo_low;
                max_value  <= stat_max_reg;
                min_value  <= stat_min_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // The count never passes its saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
    else $error("accepted count above limit");

    // A captured set leaves the accumulators cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (count_reg == '0) && (sum_reg == '0))
    else $error("accumulators not restarted after last sample");

    // A result is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
    else $error("output request overwritten");

    // A loaded result reports a match flag that agrees with its count.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (any_matched == (match_count != '0)))
    else $error("match flag and count disagree");
`endif

endmodule

@@ src/filtered_window_statistics_top.sv @@
// Filtered window statistics over a stream of tagged samples.
// Input channel (in_valid/in_ready): one sample request carries time, device,
// channel, a signed Q16.16 value and a last flag. Samples whose device and
// channel match the selected pair and whose time lies strictly inside the
// window feed a sum, a saturating count, a running maximum and a minimum.
// Output channel (out_valid/out_ready): one result request per set, issued
// after the sample flagged last: mean, maximum, minimum, count and a match flag.
// Throughput: one sample per cycle while a set accumulates. After a last
// sample the input stalls in a prep state, a divide state (a restoring divider
// makes the mean, one quotient bit per cycle) and a finish state that waits
// for a free output register; the result is valid in the cycle after its load.
// A result waiting in the output register does not stop the next set; only a
// second result that finds it still full waits for it. Configuration (cfg_valid/
// cfg_ready, cfg_index, cfg_data) is always ready; the user must write it only
// while the block is idle (not enforced). Reset clears the accumulators,
// drops the output request and restores the defaults (ceiling 1.0, others 0).
module filtered_window_statistics_top
#(
    parameter int MAX_SAMPLES     = fws_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_FRAC_BITS = fws_pkg::DEF_VALUE_FRAC_BITS,
    parameter int CNT_W           = $clog2(MAX_SAMPLES + 1)
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fws_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fws_pkg::VALUE_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [fws_pkg::TIME_W-1:0]            sample_time,
    input  logic [fws_pkg::DEV_W-1:0]             device_id,
    input  logic [fws_pkg::CH_W-1:0]              channel_id,
    input  logic signed [fws_pkg::VALUE_W-1:0]    sample_value,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fws_pkg::VALUE_W-1:0]    mean_value,
    output logic signed [fws_pkg::VALUE_W-1:0]    max_value,
    output logic signed [fws_pkg::VALUE_W-1:0]    min_value,
    output logic [CNT_W-1:0]                      match_count,
    output logic                                  any_matched
);

    localparam logic signed [fws_pkg::VALUE_W-1:0] CEIL_RST =
        fws_pkg::VALUE_W'(64'sd1 <<< VALUE_FRAC_BITS);
    localparam int CFG_ZERO_W = fws_pkg::DEV_W + fws_pkg::CH_W +
                                2 * fws_pkg::TIME_W + fws_pkg::VALUE_W;

    fws_pkg::cfg_regs_t  cfg_reg;
    fws_pkg::cfg_wr_t    cfg_wr;
    fws_pkg::ctrl_cmd_t  cmd;
    fws_pkg::dp_status_t status;
    logic                cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Floor and ceiling writes also reach the running values of an empty set.
    assign cfg_wr.floor_wr = cfg_we && (cfg_index == fws_pkg::CFG_MAX_FLOOR);
    assign cfg_wr.ceil_wr  = cfg_we && (cfg_index == fws_pkg::CFG_MIN_CEILING);
    assign cfg_wr.wdata    = cfg_data;

    // Configuration registers; every field resets to zero except the ceiling.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= {{CFG_ZERO_W{1'b0}}, CEIL_RST};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fws_pkg::CFG_DEVICE_SELECT:
                    cfg_reg.device_select  <= cfg_data[fws_pkg::DEV_W-1:0];
                fws_pkg::CFG_CHANNEL_SELECT:
                    cfg_reg.channel_select <= cfg_data[fws_pkg::CH_W-1:0];
                fws_pkg::CFG_WINDOW_START:
                    cfg_reg.window_start   <= cfg_data;
                fws_pkg::CFG_WINDOW_END:
                    cfg_reg.window_end     <= cfg_data;
                fws_pkg::CFG_MAX_FLOOR:
                    cfg_reg.max_floor      <= cfg_data;
                fws_pkg::CFG_MIN_CEILING:
                    cfg_reg.min_ceiling    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fws_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_sample (last_sample),
        .in_ready    (in_ready),
        .status      (status),
        .cmd         (cmd)
    );

    fws_dp
    #(
        .MAX_SAMPLES     (MAX_SAMPLES),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .CNT_W           (CNT_W)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cfg_wr       (cfg_wr),
        .cmd          (cmd),
        .status       (status),
        .sample_time  (sample_time),
        .device_id    (device_id),
        .channel_id   (channel_id),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_value   (mean_value),
        .max_value    (max_value),
        .min_value    (min_value),
        .match_count  (match_count),
        .any_matched  (any_matched)
    );

endmodule
